### hw/rtl/hcm_pkg.sv
// Shared types, constants and register codes of the HSV color mask unit.
package hcm_pkg;

   localparam int ChanWidth = 8;
   localparam int RawWidth  = 12;
   localparam int SrWidth   = 20;
   localparam int HrWidth   = 17;
   localparam int FracBits  = 12;
   localparam int SatProdWidth = 21;
   localparam int HueProdWidth = 30;
   localparam int TableDepth   = 256;

   localparam int SrNum = 255 * 4096;
   localparam int HrNum = 122880;

   localparam logic [ChanWidth-1:0] HueLowReset  = 8'd10;
   localparam logic [ChanWidth-1:0] HueHighReset = 8'd170;
   localparam logic                 HueInvReset  = 1'b1;
   localparam logic [ChanWidth-1:0] SatMinReset  = 8'd60;
   localparam logic [ChanWidth-1:0] ValMinReset  = 8'd60;

   typedef enum logic [2:0] {
      REG_HUE_LOW    = 3'd0,
      REG_HUE_HIGH   = 3'd1,
      REG_HUE_INVERT = 3'd2,
      REG_SAT_MIN    = 3'd3,
      REG_VAL_MIN    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ChanWidth-1:0] hue_low;
      logic [ChanWidth-1:0] hue_high;
      logic                 hue_invert;
      logic [ChanWidth-1:0] sat_min;
      logic [ChanWidth-1:0] val_min;
   } csr_type;

   typedef struct packed {
      logic [ChanWidth-1:0]       val;
      logic [ChanWidth-1:0]       diff;
      logic signed [RawWidth-1:0] raw;
   } conv_type;

   typedef struct packed {
      logic [ChanWidth-1:0]       val;
      logic [ChanWidth-1:0]       diff;
      logic signed [RawWidth-1:0] raw;
      logic [SrWidth-1:0]         sr;
      logic [HrWidth-1:0]         hr;
   } recip_type;

   typedef struct packed {
      logic [ChanWidth-1:0]           val;
      logic [SatProdWidth-1:0]        sat_prod;
      logic signed [HueProdWidth-1:0] hue_prod;
   } prod_type;

   typedef struct packed {
      logic [ChanWidth-1:0] val;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] hue;
      logic                 mask;
   } result_type;

endpackage

### hw/rtl/hcm_convert.sv
// First stage: channel maximum, minimum, spread and raw hue numerator.
module hcm_convert (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [hcm_pkg::ChanWidth-1:0]        blue,
   input  logic [hcm_pkg::ChanWidth-1:0]        green,
   input  logic [hcm_pkg::ChanWidth-1:0]        red,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output hcm_pkg::conv_type                    out_data
);

   logic                               valid_ff;
   hcm_pkg::conv_type                  data_ff;
   hcm_pkg::conv_type                  data_in;
   logic [hcm_pkg::ChanWidth-1:0]      vmax;
   logic [hcm_pkg::ChanWidth-1:0]      vmin;
   logic [hcm_pkg::ChanWidth-1:0]      diff;
   logic signed [hcm_pkg::RawWidth-1:0] b_ext;
   logic signed [hcm_pkg::RawWidth-1:0] g_ext;
   logic signed [hcm_pkg::RawWidth-1:0] r_ext;
   logic signed [hcm_pkg::RawWidth-1:0] d_ext;

   always_comb begin
      vmax = blue;
      if (green > vmax) vmax = green;
      if (red > vmax) vmax = red;
      vmin = blue;
      if (green < vmin) vmin = green;
      if (red < vmin) vmin = red;
      diff  = vmax - vmin;
      b_ext = $signed({{(hcm_pkg::RawWidth-hcm_pkg::ChanWidth){1'b0}}, blue});
      g_ext = $signed({{(hcm_pkg::RawWidth-hcm_pkg::ChanWidth){1'b0}}, green});
      r_ext = $signed({{(hcm_pkg::RawWidth-hcm_pkg::ChanWidth){1'b0}}, red});
      d_ext = $signed({{(hcm_pkg::RawWidth-hcm_pkg::ChanWidth){1'b0}}, diff});
      data_in.val  = vmax;
      data_in.diff = diff;
      if (vmax == red) begin
         data_in.raw = g_ext - b_ext;
      end else if (vmax == green) begin
         data_in.raw = b_ext - r_ext + (d_ext <<< 1);
      end else begin
         data_in.raw = r_ext - g_ext + (d_ext <<< 2);
      end
   end

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/hcm_recip.sv
// Second stage: reciprocal lookups for saturation and hue scaling.
module hcm_recip (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hcm_pkg::conv_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hcm_pkg::recip_type  out_data
);

   logic [hcm_pkg::SrWidth-1:0] sr_rom [hcm_pkg::TableDepth];
   logic [hcm_pkg::HrWidth-1:0] hr_rom [hcm_pkg::TableDepth];
   logic                        valid_ff;
   hcm_pkg::recip_type          data_ff;
   hcm_pkg::recip_type          data_in;

   for (genvar i = 0; i < hcm_pkg::TableDepth; i++) begin : g_rom
      if (i == 0) begin : g_zero
         assign sr_rom[i] = '0;
         assign hr_rom[i] = '0;
      end else begin : g_entry
         localparam int SrVal = (hcm_pkg::SrNum + i / 2) / i;
         localparam int HrVal = (hcm_pkg::HrNum + i / 2) / i;
         assign sr_rom[i] = hcm_pkg::SrWidth'(SrVal);
         assign hr_rom[i] = hcm_pkg::HrWidth'(HrVal);
      end
   end

   always_comb begin
      data_in.val  = in_data.val;
      data_in.diff = in_data.diff;
      data_in.raw  = in_data.raw;
      data_in.sr   = sr_rom[in_data.val];
      data_in.hr   = hr_rom[in_data.diff];
   end

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/hcm_mult.sv
// Third stage: fixed-point products for saturation and hue.
module hcm_mult (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hcm_pkg::recip_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hcm_pkg::prod_type   out_data
);

   logic                                    valid_ff;
   hcm_pkg::prod_type                       data_ff;
   hcm_pkg::prod_type                       data_in;
   logic signed [hcm_pkg::HrWidth:0]        hr_s;

   always_comb begin
      hr_s             = $signed({1'b0, in_data.hr});
      data_in.val      = in_data.val;
      data_in.sat_prod = hcm_pkg::SatProdWidth'(in_data.diff * in_data.sr);
      data_in.hue_prod = hcm_pkg::HueProdWidth'(in_data.raw * hr_s);
   end

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/hcm_classify.sv
// Fourth stage: rounding, hue wrap, threshold tests and the output register.
module hcm_classify (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hcm_pkg::prod_type   in_data,
   input  hcm_pkg::csr_type    csr,
   output logic                out_valid,
   input  logic                out_ready,
   output hcm_pkg::result_type out_data
);

   localparam int Half = 1 << (hcm_pkg::FracBits - 1);

   logic                                    valid_ff;
   hcm_pkg::result_type                     data_ff;
   hcm_pkg::result_type                     data_in;
   logic [hcm_pkg::SatProdWidth-1:0]        sat_sum;
   logic signed [hcm_pkg::HueProdWidth-1:0] hue_sum;
   logic [hcm_pkg::ChanWidth:0]             hue_q;
   logic [hcm_pkg::ChanWidth-1:0]           hue;
   logic                                    in_range;

   always_comb begin
      sat_sum = in_data.sat_prod + hcm_pkg::SatProdWidth'(Half);
      hue_sum = in_data.hue_prod + hcm_pkg::HueProdWidth'(Half);
      hue_q   = hue_sum[hcm_pkg::FracBits+hcm_pkg::ChanWidth:hcm_pkg::FracBits];
      if (hue_q[hcm_pkg::ChanWidth]) begin
         hue = hue_q[hcm_pkg::ChanWidth-1:0] + 8'd180;
      end else begin
         hue = hue_q[hcm_pkg::ChanWidth-1:0];
      end
      in_range     = (hue >= csr.hue_low) && (hue <= csr.hue_high);
      data_in.hue  = hue;
      data_in.sat  = sat_sum[hcm_pkg::FracBits+hcm_pkg::ChanWidth-1:hcm_pkg::FracBits];
      data_in.val  = in_data.val;
      data_in.mask = (in_range ^ csr.hue_invert) && (data_in.sat > csr.sat_min)
                     && (in_data.val > csr.val_min);
   end

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/hsv_color_mask_unit.sv
// Top level of the HSV color mask unit: register file and four-stage pixel pipeline.
// The unit takes one BGR pixel request per clock and returns its hue, saturation, value
// and mask after the fourth stage; throughput is one pixel per cycle, limited only by
// rsp_tready, since each of the four pipeline registers holds its pixel while the
// stage after it is full. Threshold registers are written through the csr_ port,
// which is always ready, and should only be changed while no pixel is in flight.
module hsv_color_mask_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue [7:0], green [15:8], red [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // mask [0], hue [8:1], sat [16:9], val [24:17], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   hcm_pkg::csr_type    csr_ff;
   hcm_pkg::csr_type    csr_in;
   hcm_pkg::conv_type   conv_data;
   hcm_pkg::recip_type  recip_data;
   hcm_pkg::prod_type   prod_data;
   hcm_pkg::result_type result;
   logic                conv_valid;
   logic                conv_ready;
   logic                recip_valid;
   logic                recip_ready;
   logic                prod_valid;
   logic                prod_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (hcm_pkg::csr_index_type'(csr_index))
            hcm_pkg::REG_HUE_LOW:    csr_in.hue_low    = csr_data;
            hcm_pkg::REG_HUE_HIGH:   csr_in.hue_high   = csr_data;
            hcm_pkg::REG_HUE_INVERT: csr_in.hue_invert = csr_data[0];
            hcm_pkg::REG_SAT_MIN:    csr_in.sat_min    = csr_data;
            hcm_pkg::REG_VAL_MIN:    csr_in.val_min    = csr_data;
            default:                 csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.hue_low    <= hcm_pkg::HueLowReset;
         csr_ff.hue_high   <= hcm_pkg::HueHighReset;
         csr_ff.hue_invert <= hcm_pkg::HueInvReset;
         csr_ff.sat_min    <= hcm_pkg::SatMinReset;
         csr_ff.val_min    <= hcm_pkg::ValMinReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   hcm_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .blue      (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .red       (req_tdata[23:16]),
      .out_valid (conv_valid),
      .out_ready (conv_ready),
      .out_data  (conv_data)
   );

   hcm_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (conv_ready),
      .in_data   (conv_data),
      .out_valid (recip_valid),
      .out_ready (recip_ready),
      .out_data  (recip_data)
   );

   hcm_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (recip_valid),
      .in_ready  (recip_ready),
      .in_data   (recip_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   hcm_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .csr       (csr_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {7'b0, result.val, result.sat, result.hue, result.mask};

endmodule

### dv/testbench.sv
// Self-checking testbench for the HSV color mask unit with a built-in pixel predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemsPerPhase = 160;
   localparam int PhaseCount    = 8;
   localparam int HoldCycles    = 300;
   localparam int IdleLimit     = 2000;
   localparam int DrainCycles   = 12;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic       mask;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } hsv_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   pixel_type        pixel_queue [$];
   hsv_type          hsv_expected [$];
   hcm_pkg::csr_type mask_cfg;
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               hold_count = 0;
   logic             hold_req = 1'b0;
   logic             hold_done = 1'b0;
   logic             quiet_mode = 1'b0;

   hsv_color_mask_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic hsv_type compute_hsv_mask(pixel_type px, hcm_pkg::csr_type cfg);
      int      b, g, r, v, mn, diff, raw, sr, hr, s, h;
      longint  prod;
      logic    in_range, hue_ok;
      hsv_type res;
      b = px.blue;
      g = px.green;
      r = px.red;
      v = b;
      mn = b;
      if (g > v) v = g;
      if (r > v) v = r;
      if (g < mn) mn = g;
      if (r < mn) mn = r;
      diff = v - mn;
      sr = (v == 0) ? 0 : (255 * 4096 + v / 2) / v;
      s = (diff * sr + 2048) >> 12;
      if (v == r) begin
         raw = g - b;
      end else if (v == g) begin
         raw = b - r + 2 * diff;
      end else begin
         raw = r - g + 4 * diff;
      end
      hr = (diff == 0) ? 0 : (180 * 4096 + 3 * diff) / (6 * diff);
      prod = longint'(raw) * longint'(hr) + 2048;
      h = int'(prod >>> 12);
      if (h < 0) h += 180;
      in_range = (h >= cfg.hue_low) && (h <= cfg.hue_high);
      hue_ok = cfg.hue_invert ? !in_range : in_range;
      res.mask = hue_ok && (s > cfg.sat_min) && (v > cfg.val_min);
      res.hue = 8'(h);
      res.sat = 8'(s);
      res.val = 8'(v);
      return res;
   endfunction

   // Random colors mixed with greys, ties, small spreads, corners and threshold neighbors.
   function automatic pixel_type random_pixel();
      pixel_type px;
      int        kind, top, base;
      logic [7:0] corner [4];
      corner = '{8'd0, 8'd1, 8'd254, 8'd255};
      kind = $urandom_range(0, 9);
      px = pixel_type'(24'($urandom));
      case (kind)
         4: begin
            px.red = 8'($urandom);
            px.green = px.red;
            px.blue = px.red;
         end
         5: begin
            top = $urandom_range(1, 255);
            px = {8'(top), 8'(top), 8'(top)};
            case ($urandom_range(0, 2))
               0: px.red = 8'($urandom_range(0, top));
               1: px.green = 8'($urandom_range(0, top));
               default: px.blue = 8'($urandom_range(0, top));
            endcase
         end
         6: begin
            base = $urandom_range(0, 251);
            px.red = 8'(base + $urandom_range(0, 4));
            px.green = 8'(base + $urandom_range(0, 4));
            px.blue = 8'(base + $urandom_range(0, 4));
         end
         7: begin
            px.red = corner[$urandom_range(0, 3)];
            px.green = corner[$urandom_range(0, 3)];
            px.blue = corner[$urandom_range(0, 3)];
         end
         8: begin
            case ($urandom_range(0, 2))
               0: px.red = 8'($urandom_range(55, 70));
               1: px.green = 8'($urandom_range(55, 70));
               default: px.blue = 8'($urandom_range(55, 70));
            endcase
         end
         9: begin
            px.red = 8'($urandom_range(0, 80));
            px.green = 8'($urandom_range(0, 80));
            px.blue = 8'($urandom_range(0, 80));
            case ($urandom_range(0, 2))
               0: px.red = 8'($urandom_range(200, 255));
               1: px.green = 8'($urandom_range(200, 255));
               default: px.blue = 8'($urandom_range(200, 255));
            endcase
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         hcm_pkg::REG_HUE_LOW:    mask_cfg.hue_low = value;
         hcm_pkg::REG_HUE_HIGH:   mask_cfg.hue_high = value;
         hcm_pkg::REG_HUE_INVERT: mask_cfg.hue_invert = value[0];
         hcm_pkg::REG_SAT_MIN:    mask_cfg.sat_min = value;
         hcm_pkg::REG_VAL_MIN:    mask_cfg.val_min = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic program_thresholds(input logic [7:0] lo, input logic [7:0] hi,
                                     input logic [7:0] inv, input logic [7:0] smin,
                                     input logic [7:0] vmin);
      write_reg(hcm_pkg::REG_HUE_LOW, lo);
      write_reg(hcm_pkg::REG_HUE_HIGH, hi);
      write_reg(hcm_pkg::REG_HUE_INVERT, inv);
      write_reg(hcm_pkg::REG_SAT_MIN, smin);
      write_reg(hcm_pkg::REG_VAL_MIN, vmin);
   endtask

   always @(posedge clock) begin : drive_proc
      pixel_type sent;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent = pixel_queue.pop_front();
            hsv_expected = {hsv_expected, compute_hsv_mask(sent, mask_cfg)};
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (pixel_queue.size() != 0 &&
                      (quiet_mode || $urandom_range(0, 99) >= 34)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pixel_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : collect_proc
      hsv_type got;
      hsv_type want;
      logic    next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.mask = rsp_tdata[0];
            got.hue = rsp_tdata[8:1];
            got.sat = rsp_tdata[16:9];
            got.val = rsp_tdata[24:17];
            if (hsv_expected.size() == 0) begin
               $error("result arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = hsv_expected.pop_front();
               if (got.mask !== want.mask) begin
                  $error("mask: expected %0d, got %0d", want.mask, got.mask);
                  mismatch_count++;
               end
               if (got.hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, got.hue);
                  mismatch_count++;
               end
               if (got.sat !== want.sat) begin
                  $error("sat: expected %0d, got %0d", want.sat, got.sat);
                  mismatch_count++;
               end
               if (got.val !== want.val) begin
                  $error("val: expected %0d, got %0d", want.val, got.val);
                  mismatch_count++;
               end
            end
         end
         if (hold_req && !hold_done) begin
            next_ready = 1'b0;
            if (hold_count >= HoldCycles) hold_done <= 1'b1;
            hold_count <= hold_count + 1;
         end else begin
            next_ready = quiet_mode || ($urandom_range(0, 99) >= 34);
         end
         rsp_tready <= next_ready;
      end
   end

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("hsv_color_mask_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus_proc
      logic [23:0] directed [];
      directed = {24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
                  24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0AC8,
                  24'hFFC80A, 24'hFEFF00, 24'hFE00FF, 24'hFFFFFE, 24'h000001,
                  24'h000100, 24'h010000, 24'hAA55AA, 24'h55AA55, 24'hC83D3D,
                  24'h3D0000, 24'h3C0000, 24'h0100FF};
      mask_cfg.hue_low = hcm_pkg::HueLowReset;
      mask_cfg.hue_high = hcm_pkg::HueHighReset;
      mask_cfg.hue_invert = hcm_pkg::HueInvReset;
      mask_cfg.sat_min = hcm_pkg::SatMinReset;
      mask_cfg.val_min = hcm_pkg::ValMinReset;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         while (pixel_queue.size() != 0 || hsv_expected.size() != 0) @(negedge clock);
         repeat (8) @(posedge clock);
         case (phase)
            0: ;
            1: begin
               // Spare indexes must leave every threshold untouched.
               for (int idx = int'(hcm_pkg::REG_VAL_MIN) + 1;
                    idx < (1 << $bits(csr_index)); idx++)
                  write_reg(3'(idx), 8'hFF);
               program_thresholds(8'd40, 8'd65, 8'hFE, 8'd60, 8'd60);
            end
            2: program_thresholds(8'd0, 8'd255, 8'h00, 8'd0, 8'd0);
            3: program_thresholds(8'd255, 8'd0, 8'hFF, 8'd255, 8'd255);
            4: program_thresholds(8'd0, 8'd0, 8'h00, 8'd0, 8'd0);
            default: program_thresholds(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                                        8'($urandom), 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
         endcase
         @(negedge clock);
         quiet_mode = (phase == 1);
         if (phase == 3) hold_req = 1'b1;
         if (phase == 0 || phase == 2) begin
            foreach (directed[i]) pixel_queue = {pixel_queue, pixel_type'(directed[i])};
         end
         repeat (ItemsPerPhase) pixel_queue = {pixel_queue, random_pixel()};
      end

      while (pixel_queue.size() != 0 || hsv_expected.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("hsv_color_mask_unit: match");
      end else begin
         $display("hsv_color_mask_unit: mismatch");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/hcm_pkg.sv
hw/rtl/hcm_convert.sv
hw/rtl/hcm_recip.sv
hw/rtl/hcm_mult.sv
hw/rtl/hcm_classify.sv
hw/rtl/hsv_color_mask_unit.sv
dv/testbench.sv
